// ===== design/analog_stick_radial_deadzone_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the analog stick radial deadzone unit
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ANALOG_STICK_RADIAL_DEADZONE_UNIT_ASSERT_SVH
`define ANALOG_STICK_RADIAL_DEADZONE_UNIT_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define ASRD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define ASRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/asrd_pkg.sv =====
// ----------------------------------------------------------------------------
// asrd_pkg
// Shared widths, codes and controller/datapath types of the radial deadzone.
// ----------------------------------------------------------------------------
package asrd_pkg;

    localparam int NUM_STICKS = 2;
    localparam int HIST_W     = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;

    localparam int RAW_W  = 8;
    localparam int DZ_W   = 14;
    localparam int OUT_W  = 16;
    localparam int SQ_W   = 16;
    localparam int ROOT_W = 30;
    localparam int MAG_W  = 15;
    localparam int PROD_W = 23;
    localparam int DEN_W  = 30;
    localparam int NUM_W  = 46;
    localparam int DIV_W  = 31;
    localparam int QUO_W  = 17;
    localparam int CNT_W  = 5;

    localparam int ROOT_STEPS = 15;
    localparam int DIV_STEPS  = 17;

    localparam logic [DZ_W-1:0]  DZ_RESET    = 14'd2621;
    localparam logic [MAG_W-1:0] ONE_Q14     = 15'd16384;
    localparam logic [QUO_W-1:0] POS_LIMIT   = 17'd32767;
    localparam logic [QUO_W-1:0] NEG_LIMIT   = 17'd32768;
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MIN = 16'h8000;

    localparam int              CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd1;

    typedef enum logic [1:0] {
        ACT_DOWN = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_UP   = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_TEST,
        ST_ROOT,
        ST_PROD,
        ST_NUMER,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic test;
        logic root_step;
        logic prod;
        logic numer;
        logic div_load;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic below;
        logic in_zone;
        logic out_free;
    } status_t;

endpackage

// ===== design/asrd_div.sv =====
// ----------------------------------------------------------------------------
// asrd_div
// Restoring divider, one quotient bit a cycle while step is asserted, with an overflow flag.
// ----------------------------------------------------------------------------
module asrd_div (
    input  logic                         aclk,
    input  logic                         load,
    input  logic                         step,
    input  logic [asrd_pkg::NUM_W-1:0]   num,
    input  logic [asrd_pkg::DIV_W-1:0]   den,
    output logic [asrd_pkg::QUO_W-1:0]   quo,
    output logic                         ovf
);

    logic [asrd_pkg::NUM_W-1:0] rem_reg;
    logic [asrd_pkg::NUM_W-1:0] rem_next;
    logic [asrd_pkg::NUM_W:0]   dsh_reg;
    logic [asrd_pkg::QUO_W-1:0] quo_reg;
    logic [asrd_pkg::QUO_W-1:0] quo_next;
    logic                       ovf_reg;
    logic                       fits;

    always_comb begin
        fits     = {1'b0, rem_reg} >= dsh_reg;
        rem_next = fits ? (rem_reg - dsh_reg[asrd_pkg::NUM_W-1:0]) : rem_reg;
        quo_next = {quo_reg[asrd_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= num;
            dsh_reg <= {den, {(asrd_pkg::QUO_W-1){1'b0}}};
            quo_reg <= '0;
            ovf_reg <= {2'b00, num} >= {den, {asrd_pkg::QUO_W{1'b0}}};
        end else if (step) begin
            rem_reg <= rem_next;
            dsh_reg <= {1'b0, dsh_reg[asrd_pkg::NUM_W:1]};
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule

// ===== design/asrd_dp.sv =====
// ----------------------------------------------------------------------------
// asrd_dp
// Datapath: squares, deadzone test, bitwise square root, scaling products,
// two dividers, saturation, event history and the output register.
// ----------------------------------------------------------------------------
module asrd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asrd_pkg::cmd_t                cmd,
    output asrd_pkg::status_t             status,
    input  logic                          s_tuser,
    input  logic [15:0]                   s_tdata,
    input  logic [asrd_pkg::DZ_W-1:0]     left_dz,
    input  logic [asrd_pkg::DZ_W-1:0]     right_dz,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic [2:0]                    m_tuser
);

    logic [asrd_pkg::RAW_W-1:0]  raw_h;
    logic [asrd_pkg::RAW_W-1:0]  raw_v;
    logic [asrd_pkg::RAW_W-1:0]  magx_in;
    logic [asrd_pkg::RAW_W-1:0]  magy_in;

    logic                        sel_reg;
    logic                        negx_reg;
    logic                        negy_reg;
    logic [asrd_pkg::RAW_W-1:0]  magx_reg;
    logic [asrd_pkg::RAW_W-1:0]  magy_reg;
    logic [asrd_pkg::DZ_W-1:0]   dz_reg;
    logic [asrd_pkg::SQ_W-1:0]   s_reg;
    logic [2*asrd_pkg::DZ_W-1:0] dzsq_reg;
    logic [asrd_pkg::ROOT_W-1:0] rem_reg;
    logic [asrd_pkg::ROOT_W-1:0] root_reg;
    logic [asrd_pkg::ROOT_W-1:0] bit_reg;
    logic [asrd_pkg::PROD_W-1:0] prodx_reg;
    logic [asrd_pkg::PROD_W-1:0] prody_reg;
    logic [asrd_pkg::DEN_W-1:0]  den_reg;
    logic [asrd_pkg::NUM_W-1:0]  numx_reg;
    logic [asrd_pkg::NUM_W-1:0]  numy_reg;
    logic [asrd_pkg::DIV_W-1:0]  dvs_reg;
    logic                        zero_reg;

    logic [2*asrd_pkg::RAW_W-1:0] sqx;
    logic [2*asrd_pkg::RAW_W-1:0] sqy;
    logic [2*asrd_pkg::RAW_W:0]   sq_sum;
    logic [asrd_pkg::ROOT_W-1:0]  scaled_s;
    logic [asrd_pkg::ROOT_W-1:0]  trial;
    logic                         root_ge;
    logic [asrd_pkg::MAG_W-1:0]   m_val;
    logic [asrd_pkg::MAG_W-1:0]   dz_ext;
    logic [asrd_pkg::MAG_W-1:0]   diff;
    logic [asrd_pkg::MAG_W-1:0]   span;

    logic [asrd_pkg::QUO_W-1:0]   quox;
    logic [asrd_pkg::QUO_W-1:0]   quoy;
    logic                         ovfx;
    logic                         ovfy;
    logic [asrd_pkg::OUT_W-1:0]   ox;
    logic [asrd_pkg::OUT_W-1:0]   oy;
    logic                         cur_zero;
    logic [asrd_pkg::HIST_W-1:0]  hidx;
    logic                         act_up;
    logic                         act_down;
    asrd_pkg::action_t            action;

    logic                         last_zero_reg [asrd_pkg::NUM_STICKS];
    logic                         blast_zero_reg [asrd_pkg::NUM_STICKS];
    logic                         m_tvalid_reg;
    logic                         stick_id_reg;
    logic [asrd_pkg::OUT_W-1:0]   out_h_reg;
    logic [asrd_pkg::OUT_W-1:0]   out_v_reg;
    asrd_pkg::action_t            action_reg;

    function automatic logic [asrd_pkg::OUT_W-1:0] saturate(
        input logic                       neg,
        input logic [asrd_pkg::QUO_W-1:0] q,
        input logic                       ovf
    );
        logic [asrd_pkg::QUO_W-1:0] negq;
        negq = '0 - q;
        if (neg) begin
            if (ovf || (q > asrd_pkg::NEG_LIMIT)) begin
                return asrd_pkg::OUT_NEG_MIN;
            end
            return negq[asrd_pkg::OUT_W-1:0];
        end
        if (ovf || (q > asrd_pkg::POS_LIMIT)) begin
            return asrd_pkg::OUT_POS_MAX;
        end
        return q[asrd_pkg::OUT_W-1:0];
    endfunction

    assign raw_h   = s_tdata[7:0];
    assign raw_v   = s_tdata[15:8];
    assign magx_in = raw_h[7] ? {1'b0, raw_h[6:0]} : 8'(9'd128 - {1'b0, raw_h});
    assign magy_in = raw_v[7] ? {1'b0, raw_v[6:0]} : 8'(9'd128 - {1'b0, raw_v});

    always_comb begin
        sqx      = magx_reg * magx_reg;
        sqy      = magy_reg * magy_reg;
        sq_sum   = {1'b0, sqx} + {1'b0, sqy};
        scaled_s = {s_reg, {asrd_pkg::DZ_W{1'b0}}};
        trial    = root_reg + bit_reg;
        root_ge  = rem_reg >= trial;
        m_val    = root_reg[asrd_pkg::MAG_W-1:0];
        dz_ext   = {1'b0, dz_reg};
        diff     = m_val - dz_ext;
        span     = asrd_pkg::ONE_Q14 - dz_ext;
    end

    assign status.below    = (s_reg == '0) || ({2'b00, dzsq_reg} > scaled_s);
    assign status.in_zone  = m_val <= dz_ext;
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sel_reg  <= s_tuser;
            negx_reg <= ~raw_h[7];
            negy_reg <= ~raw_v[7];
            magx_reg <= magx_in;
            magy_reg <= magy_in;
            dz_reg   <= s_tuser ? right_dz : left_dz;
            zero_reg <= 1'b0;
        end
        if (cmd.square) begin
            s_reg    <= sq_sum[asrd_pkg::SQ_W-1:0];
            dzsq_reg <= dz_reg * dz_reg;
        end
        if (cmd.test) begin
            zero_reg <= status.below;
            rem_reg  <= scaled_s;
            root_reg <= '0;
            bit_reg  <= asrd_pkg::ROOT_W'(1) << (asrd_pkg::ROOT_W - 2);
        end
        if (cmd.root_step) begin
            if (root_ge) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.prod) begin
            zero_reg  <= status.in_zone;
            prodx_reg <= magx_reg * diff;
            prody_reg <= magy_reg * diff;
            den_reg   <= m_val * span;
        end
        if (cmd.numer) begin
            numx_reg <= {1'b0, prodx_reg, 22'd0} + {16'd0, den_reg};
            numy_reg <= {1'b0, prody_reg, 22'd0} + {16'd0, den_reg};
            dvs_reg  <= {den_reg, 1'b0};
        end
    end

    asrd_div u_div_x (
        .aclk (aclk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (numx_reg),
        .den  (dvs_reg),
        .quo  (quox),
        .ovf  (ovfx)
    );

    asrd_div u_div_y (
        .aclk (aclk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (numy_reg),
        .den  (dvs_reg),
        .quo  (quoy),
        .ovf  (ovfy)
    );

    always_comb begin
        ox       = zero_reg ? '0 : saturate(negx_reg, quox, ovfx);
        oy       = zero_reg ? '0 : saturate(negy_reg, quoy, ovfy);
        cur_zero = (ox == '0) && (oy == '0);
        hidx     = (int'(sel_reg) < asrd_pkg::NUM_STICKS) ? asrd_pkg::HIST_W'(sel_reg)
                                                          : asrd_pkg::HIST_W'(asrd_pkg::NUM_STICKS - 1);
        act_up   = cur_zero && last_zero_reg[hidx] && !blast_zero_reg[hidx];
        act_down = !cur_zero && last_zero_reg[hidx] && blast_zero_reg[hidx];
        action   = act_up ? asrd_pkg::ACT_UP : (act_down ? asrd_pkg::ACT_DOWN : asrd_pkg::ACT_MOVE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < asrd_pkg::NUM_STICKS; i++) begin
                last_zero_reg[i]  <= 1'b1;
                blast_zero_reg[i] <= 1'b1;
            end
        end else if (cmd.finish) begin
            m_tvalid_reg         <= 1'b1;
            blast_zero_reg[hidx] <= last_zero_reg[hidx];
            last_zero_reg[hidx]  <= cur_zero;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            stick_id_reg <= sel_reg;
            out_h_reg    <= ox;
            out_v_reg    <= oy;
            action_reg   <= action;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_v_reg, out_h_reg};
    assign m_tuser  = {action_reg, stick_id_reg};

endmodule

// ===== design/asrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// asrd_ctrl
// Sequencer that steps the datapath through one sample at a time.
// ----------------------------------------------------------------------------
module asrd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  asrd_pkg::status_t  status,
    output asrd_pkg::cmd_t     cmd
);

    asrd_pkg::state_t            state_reg;
    asrd_pkg::state_t            state_next;
    logic [asrd_pkg::CNT_W-1:0]  cnt_reg;
    logic [asrd_pkg::CNT_W-1:0]  cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asrd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            asrd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = asrd_pkg::ST_SQUARE;
                end
            end
            asrd_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = asrd_pkg::ST_TEST;
            end
            asrd_pkg::ST_TEST: begin
                cmd.test = 1'b1;
                if (status.below) begin
                    state_next = asrd_pkg::ST_FINISH;
                end else begin
                    state_next = asrd_pkg::ST_ROOT;
                    cnt_next   = asrd_pkg::CNT_W'(asrd_pkg::ROOT_STEPS - 1);
                end
            end
            asrd_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = asrd_pkg::ST_PROD;
                end
            end
            asrd_pkg::ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = status.in_zone ? asrd_pkg::ST_FINISH : asrd_pkg::ST_NUMER;
            end
            asrd_pkg::ST_NUMER: begin
                cmd.numer  = 1'b1;
                state_next = asrd_pkg::ST_LOAD;
            end
            asrd_pkg::ST_LOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = asrd_pkg::CNT_W'(asrd_pkg::DIV_STEPS - 1);
                state_next   = asrd_pkg::ST_DIVIDE;
            end
            asrd_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = asrd_pkg::ST_FINISH;
                end
            end
            asrd_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = asrd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = asrd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/analog_stick_radial_deadzone_unit.sv =====
// ----------------------------------------------------------------------------
// analog_stick_radial_deadzone_unit
// Scaled radial deadzone for two analog sticks with a down/move/up classifier.
//
//   Channel   Direction  Handshake          Word
//   s_        in         s_tvalid/s_tready  tdata: raw x, raw y; tuser: stick
//   m_        out        m_tvalid/m_tready  tdata: out x, out y; tuser: stick, action
//   cfg_      in         cfg_valid/cfg_ready index and deadzone value
//
// A sample outside the deadzone passes through the squares, the deadzone test,
// the bitwise square root, the scaling products, the numerators, the divider
// load and the two dividers before its result word. A sample below the deadzone
// by the squared test goes from the test to its result, and one whose magnitude
// comes out no larger than the deadzone goes there from the scaling products.
// One sample is processed at a time; the next can be taken once the result sits
// in the output register, and a stalled output holds the sequencer in its last step.
// Reset is synchronous and active low; deadzones return to 2621 and all
// history flags to one, as after a zero reading.
// ----------------------------------------------------------------------------
module analog_stick_radial_deadzone_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // raw_horizontal, raw_vertical
    input  logic                              s_tuser,   // stick_select
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // out_horizontal, out_vertical
    output logic [2:0]                        m_tuser,   // stick_id, action
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [asrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asrd_pkg::DZ_W-1:0]         cfg_data
);

    logic [asrd_pkg::DZ_W-1:0] left_dz_reg;
    logic [asrd_pkg::DZ_W-1:0] right_dz_reg;
    asrd_pkg::cmd_t            cmd;
    asrd_pkg::status_t         status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_dz_reg  <= asrd_pkg::DZ_RESET;
            right_dz_reg <= asrd_pkg::DZ_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                asrd_pkg::CFG_LEFT_DZ:  left_dz_reg  <= cfg_data;
                asrd_pkg::CFG_RIGHT_DZ: right_dz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    asrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asrd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .left_dz  (left_dz_reg),
        .right_dz (right_dz_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/asrd_checker.sv =====
// ----------------------------------------------------------------------------
// asrd_checker
// Port-level checks on the radial deadzone unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "analog_stick_radial_deadzone_unit_assert.svh"

module asrd_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [15:0]                       s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [31:0]                       m_tdata,
    input  logic [2:0]                        m_tuser,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [asrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asrd_pkg::DZ_W-1:0]         cfg_data
);

    logic out_wait;
    logic in_take;
    logic is_up;
    logic is_down;

    assign out_wait = m_tvalid && !m_tready;
    assign in_take  = s_tvalid && s_tready;
    assign is_up    = m_tvalid && (m_tuser[2:1] == asrd_pkg::ACT_UP);
    assign is_down  = m_tvalid && (m_tuser[2:1] == asrd_pkg::ACT_DOWN);

    `ASRD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_wait, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Result word changed while stalled")
    `ASRD_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, in_take, !s_tready, "Input taken while a sample is in progress")
    `ASRD_ASSERT_SAME(a_up_is_zero, aclk, aresetn, is_up, m_tdata == 32'd0, "Up event carries a nonzero vector")
    `ASRD_ASSERT_SAME(a_down_is_nonzero, aclk, aresetn, is_down, m_tdata != 32'd0, "Down event carries a zero vector")

endmodule

bind analog_stick_radial_deadzone_unit asrd_checker u_asrd_checker (.*);
